// ===== rtl/core/sem_pkg.sv =====
// Shared types, constants and widths for the Sobel edge magnitude block.
// Depends on nothing; every other file in rtl/core but sem_ram imports it.
`timescale 1ns / 1ps

package sem_pkg;

   // Frame limits and derived widths
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int PIX_W      = 8;
   localparam int RGB_W      = 3 * PIX_W;
   localparam int WID_W      = 11;
   localparam int HGT_W      = 13;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT + 2);
   localparam int TOTAL_W    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = HGT_W;

   // Gradient arithmetic
   localparam int SUM_W      = 10;
   localparam int GRAD_W     = 12;
   localparam int SQ_W       = 20;
   localparam int SS_W       = SQ_W + 1;
   localparam int ROOT_SAT   = 255 * 255 + 255 + 1;
   localparam int ROOT_STEPS = PIX_W;
   localparam int STEP_W     = $clog2(ROOT_STEPS);
   localparam int RAD_W      = 2 * PIX_W;
   localparam int REM_W      = PIX_W + 1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_GRAD,
      ST_SQR,
      ST_LOAD,
      ST_ROOT,
      ST_DONE
   } sem_state_type;

   typedef struct packed {
      logic grad_en;
      logic sqr_en;
      logic root_load;
      logic root_step;
   } sem_lane_ctrl_type;

   typedef logic [2:0][2:0][PIX_W-1:0] sem_win_type;

endpackage

// ===== rtl/core/sem_if.sv =====
// Channel interfaces for the Sobel block: pixel words in, result words out, register writes.
// Depends on sem_pkg for field widths.
`timescale 1ns / 1ps

interface sem_req_if import sem_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             req_type;
   logic [PIX_W-1:0] in_red;
   logic [PIX_W-1:0] in_green;
   logic [PIX_W-1:0] in_blue;
   modport source (output valid, req_type, in_red, in_green, in_blue, input ready);
   modport sink   (input valid, req_type, in_red, in_green, in_blue, output ready);
endinterface

interface sem_rsp_if import sem_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] out_red;
   logic [PIX_W-1:0] out_green;
   logic [PIX_W-1:0] out_blue;
   logic             out_last;
   modport source (output valid, out_red, out_green, out_blue, out_last, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_last, output ready);
endinterface

interface sem_csr_if import sem_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  addr;
   logic [CSR_DATA_W-1:0] wdata;
   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

// ===== rtl/core/sobel_edge_magnitude_rgb.sv =====
// Sobel edge magnitude on an RGB raster stream. Each accepted word is a pixel or a
// padding tick; a result word (one gradient magnitude per colour, rounded and capped
// at 255) follows one row and one pixel behind, so image_width+1 padding ticks flush
// a frame, and out_last marks its final result. A word that yields a result passes
// through line-store read, gradient, square, root load, the eight-step square-root
// iteration each colour lane runs in parallel, and output; other words only the line-store
// read and write. Writing either register restarts the frame; write only while the block is idle.
`timescale 1ns / 1ps

module sobel_edge_magnitude_rgb import sem_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   sem_req_if.sink   req_bus,
   sem_rsp_if.source rsp_bus,
   sem_csr_if.sink   csr_bus
);

   sem_state_type                state_ff, state_in;
   logic [WID_W-1:0]             width_ff, width_in;
   logic [HGT_W-1:0]             height_ff, height_in;
   logic [TOTAL_W-1:0]           total_ff;
   logic [WID_W+HGT_W-1:0]       prod;
   logic [COL_W-1:0]             col_ff, addr_ff;
   logic [ROW_W-1:0]             row_ff;
   logic [TOTAL_W-1:0]           emitted_ff;
   logic [RGB_W-1:0]             pix_ff;
   logic [2:0]                   rmask_ff, rmask_in, cmask_ff, cmask_in;
   logic                         emit_ff, emit_in, last_ff, last_in;
   logic [2:0][2:0][RGB_W-1:0]   window_ff;
   logic [STEP_W-1:0]            step_ff;
   logic [RGB_W-1:0]             upper_rd, middle_rd;
   logic                         accept, csr_wr, ram_we, rsp_load, rsp_valid_ff;
   sem_lane_ctrl_type            lane_ctrl;
   sem_win_type                  lane_win [3];
   logic [PIX_W-1:0]             lane_mag [3];
   logic [PIX_W-1:0]             red_ff, green_ff, blue_ff;
   logic                         out_last_ff;
   logic signed [ROW_W+1:0]      cr, hs;
   logic signed [WID_W+1:0]      cc, ws;
   logic [WID_W-1:0]             col_inc;

   assign accept = req_bus.valid && req_bus.ready;
   assign csr_wr = csr_bus.valid && csr_bus.ready;
   assign csr_bus.ready = 1'b1;

   // Clamp register writes into range
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr) begin
         unique case (csr_bus.addr)
            REG_IMAGE_WIDTH: begin
               width_in = csr_bus.wdata[WID_W-1:0];
               if (width_in == '0) width_in = WID_W'(1);
               else if (width_in > WID_W'(MAX_WIDTH)) width_in = WID_W'(MAX_WIDTH);
            end
            REG_IMAGE_HEIGHT: begin
               height_in = csr_bus.wdata[HGT_W-1:0];
               if (height_in == '0) height_in = HGT_W'(1);
               else if (height_in > HGT_W'(MAX_HEIGHT)) height_in = HGT_W'(MAX_HEIGHT);
            end
            default: begin
            end
         endcase
      end
   end
   assign prod = width_in * height_in;

   // Centre position and boundary masks of the result this word completes
   assign hs = $signed({2'b00, height_ff});
   assign ws = $signed({2'b00, width_ff});
   always_comb begin
      cr = (col_ff != '0) ? (ROW_W+2)'($signed({2'b00, row_ff}) - 1)
                          : (ROW_W+2)'($signed({2'b00, row_ff}) - 2);
      cc = (col_ff != '0) ? (WID_W+2)'($signed({1'b0, 2'b00, col_ff}) - 1)
                          : (WID_W+2)'(ws - 1);
      rmask_in[0] = (cr - 1 >= 0) && (cr - 1 < hs);
      rmask_in[1] = (cr >= 0) && (cr < hs);
      rmask_in[2] = (cr + 1 >= 0) && (cr + 1 < hs);
      cmask_in[0] = (cc - 1 >= 0) && (cc - 1 < ws);
      cmask_in[1] = (cc >= 0) && (cc < ws);
      cmask_in[2] = (cc + 1 >= 0) && (cc + 1 < ws);
      emit_in = ((row_ff >= ROW_W'(2)) || (row_ff == ROW_W'(1) && col_ff != '0))
                && (emitted_ff < total_ff);
      last_in = emit_in && (emitted_ff + 1'b1 == total_ff);
      col_inc = WID_W'(col_ff) + 1'b1;
   end

   // Hold configuration and stream position
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WID_W'(MAX_WIDTH);
         height_ff  <= HGT_W'(1024);
         total_ff   <= TOTAL_W'(MAX_WIDTH * 1024);
         col_ff     <= '0;
         row_ff     <= '0;
         emitted_ff <= '0;
      end else if (csr_wr) begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         total_ff   <= prod[TOTAL_W-1:0];
         col_ff     <= '0;
         row_ff     <= '0;
         emitted_ff <= '0;
      end else if (accept) begin
         if (last_in) begin
            col_ff     <= '0;
            row_ff     <= '0;
            emitted_ff <= '0;
         end else begin
            emitted_ff <= emitted_ff + TOTAL_W'(emit_in);
            if (col_inc >= width_ff) begin
               col_ff <= '0;
               if (row_ff <= ROW_W'(MAX_HEIGHT)) row_ff <= row_ff + 1'b1;
            end else begin
               col_ff <= col_inc[COL_W-1:0];
            end
         end
      end
   end

   // Capture the word and its flags
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff   <= req_bus.req_type ? '0
                     : {req_bus.in_red, req_bus.in_green, req_bus.in_blue};
         addr_ff  <= col_ff;
         rmask_ff <= rmask_in;
         cmask_ff <= cmask_in;
         emit_ff  <= emit_in;
         last_ff  <= last_in;
      end
   end

   // Line stores: two rows back and one row back
   sem_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_upper (
      .clock (clock), .we (ram_we), .waddr (addr_ff), .wdata (middle_rd),
      .raddr (col_ff), .rdata (upper_rd)
   );
   sem_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_middle (
      .clock (clock), .we (ram_we), .waddr (addr_ff), .wdata (pix_ff),
      .raddr (col_ff), .rdata (middle_rd)
   );

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_ROOT) step_ff <= step_ff + 1'b1;
         else step_ff <= '0;
      end
   end

   // Sequence one word through read and, if it yields a result, gradient, square and root
   always_comb begin
      state_in       = state_ff;
      req_bus.ready  = 1'b0;
      ram_we         = 1'b0;
      rsp_load       = 1'b0;
      lane_ctrl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) state_in = ST_READ;
         end
         ST_READ: begin
            ram_we   = 1'b1;
            state_in = emit_ff ? ST_GRAD : ST_IDLE;
         end
         ST_GRAD: begin
            lane_ctrl.grad_en = 1'b1;
            state_in = ST_SQR;
         end
         ST_SQR: begin
            lane_ctrl.sqr_en = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            lane_ctrl.root_load = 1'b1;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            lane_ctrl.root_step = 1'b1;
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Shift the window; clear it on restart and after the last result
   always_ff @(posedge clock) begin
      if (reset || csr_wr || (rsp_load && last_ff)) begin
         window_ff <= '0;
      end else if (ram_we) begin
         for (int i = 0; i < 3; i++) begin
            window_ff[i][0] <= window_ff[i][1];
            window_ff[i][1] <= window_ff[i][2];
         end
         window_ff[0][2] <= upper_rd;
         window_ff[1][2] <= middle_rd;
         window_ff[2][2] <= pix_ff;
      end
   end

   // Colour lanes, red first
   for (genvar ch = 0; ch < 3; ch++) begin : g_lane
      for (genvar i = 0; i < 3; i++) begin : g_row
         for (genvar j = 0; j < 3; j++) begin : g_col
            assign lane_win[ch][i][j] = window_ff[i][j][PIX_W*(2-ch) +: PIX_W];
         end
      end
      sem_lane u_lane (
         .clock    (clock),
         .ctrl     (lane_ctrl),
         .win      (lane_win[ch]),
         .row_mask (rmask_ff),
         .col_mask (cmask_ff),
         .mag      (lane_mag[ch])
      );
   end

   // Merge the lanes into the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         red_ff      <= lane_mag[0];
         green_ff    <= lane_mag[1];
         blue_ff     <= lane_mag[2];
         out_last_ff <= last_ff;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_red   = red_ff;
   assign rsp_bus.out_green = green_ff;
   assign rsp_bus.out_blue  = blue_ff;
   assign rsp_bus.out_last  = out_last_ff;

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_READ)
      else $error("accepted word did not move to line-store read");

   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      WID_W'(col_ff) < width_ff)
      else $error("column position beyond image width");

   a_emitted_bound: assert property (@(posedge clock) disable iff (reset)
      emitted_ff <= total_ff)
      else $error("more results than pixels in the frame");

   a_load_not_lost: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_bus.ready))
      else $error("result loaded over one not yet taken");

endmodule

// ===== rtl/core/sem_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; used for the two line stores.
`timescale 1ns / 1ps

module sem_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== rtl/core/sem_lane.sv =====
// One colour lane: masked Sobel gradients, squares, and an iterative rounded square root.
// Depends on sem_pkg for widths and the lane control struct.
`timescale 1ns / 1ps

module sem_lane import sem_pkg::*; (
   input  logic              clock,
   input  sem_lane_ctrl_type ctrl,
   input  sem_win_type       win,
   input  logic [2:0]        row_mask,
   input  logic [2:0]        col_mask,
   output logic [PIX_W-1:0]  mag
);

   sem_win_type              m;
   logic [SUM_W-1:0]         gx_pos, gx_neg, gy_pos, gy_neg;
   logic signed [GRAD_W-1:0] gx_in, gy_in, gx_ff, gy_ff;
   logic signed [2*GRAD_W-1:0] px, py;
   logic [SQ_W-1:0]          sqx_ff, sqy_ff;
   logic [SS_W-1:0]          ss;
   logic [RAD_W-1:0]         rad_ff, rad_in;
   logic [PIX_W-1:0]         root_ff, root_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic                     sat_ff;
   logic [REM_W+1:0]         rem_sh, trial;

   // Drop out-of-frame neighbours
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            m[i][j] = (row_mask[i] && col_mask[j]) ? win[i][j] : '0;
         end
      end
   end

   // Kernel sums: right minus left column, bottom minus top row
   assign gx_pos = SUM_W'(m[0][2]) + SUM_W'({m[1][2], 1'b0}) + SUM_W'(m[2][2]);
   assign gx_neg = SUM_W'(m[0][0]) + SUM_W'({m[1][0], 1'b0}) + SUM_W'(m[2][0]);
   assign gy_pos = SUM_W'(m[2][0]) + SUM_W'({m[2][1], 1'b0}) + SUM_W'(m[2][2]);
   assign gy_neg = SUM_W'(m[0][0]) + SUM_W'({m[0][1], 1'b0}) + SUM_W'(m[0][2]);
   assign gx_in  = $signed({2'b00, gx_pos}) - $signed({2'b00, gx_neg});
   assign gy_in  = $signed({2'b00, gy_pos}) - $signed({2'b00, gy_neg});

   assign px = gx_ff * gx_ff;
   assign py = gy_ff * gy_ff;
   assign ss = SS_W'(sqx_ff) + SS_W'(sqy_ff);

   // One root bit per step
   assign rem_sh = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial  = (REM_W+2)'({root_ff, 2'b01});
   always_comb begin
      if (rem_sh >= trial) begin
         rem_in  = REM_W'(rem_sh - trial);
         root_in = {root_ff[PIX_W-2:0], 1'b1};
      end else begin
         rem_in  = REM_W'(rem_sh);
         root_in = {root_ff[PIX_W-2:0], 1'b0};
      end
      rad_in = {rad_ff[RAD_W-3:0], 2'b00};
   end

   // Advance the lane stages
   always_ff @(posedge clock) begin
      if (ctrl.grad_en) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
      end
      if (ctrl.sqr_en) begin
         sqx_ff <= px[SQ_W-1:0];
         sqy_ff <= py[SQ_W-1:0];
      end
      if (ctrl.root_load) begin
         sat_ff  <= (ss >= SS_W'(ROOT_SAT));
         rad_ff  <= ss[RAD_W-1:0];
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (ctrl.root_step) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   // Round to nearest: remainder above root rounds up
   assign mag = sat_ff ? '1 :
                (rem_ff > REM_W'(root_ff)) ? root_ff + 1'b1 : root_ff;

endmodule
